>>> rtl/core/rcpq_pkg.sv
// Shared types, constants and register indexes of the RC PWM pulse qualifier.
package rcpq_pkg;

  localparam int TIME_W      = 32;
  localparam int WIDTH_W     = 16;
  localparam int CNT_W       = 6;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int OUT_TDATA_W = 40;

  localparam int AVG_SAMPLES_DEF = 8;

  // Shared divider: 24-bit dividend covers |avg - left| * 200.
  localparam int DIV_DW = 24;
  localparam int DIV_VW = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_DEADBAND_LOW     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DEADBAND_HIGH    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_PULSES    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_TRIGGER_COUNT    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_FULL_LEFT_WIDTH  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_FULL_RIGHT_WIDTH = 3'd5;

  localparam logic [WIDTH_W-1:0] DEADBAND_LOW_RST     = 16'd1420;
  localparam logic [WIDTH_W-1:0] DEADBAND_HIGH_RST    = 16'd1500;
  localparam logic [CNT_W-1:0]   WINDOW_PULSES_RST    = 6'd20;
  localparam logic [CNT_W-1:0]   TRIGGER_COUNT_RST    = 6'd5;
  localparam logic [WIDTH_W-1:0] FULL_LEFT_WIDTH_RST  = 16'd1000;
  localparam logic [WIDTH_W-1:0] FULL_RIGHT_WIDTH_RST = 16'd2000;

  localparam logic CMD_RISE = 1'b0;
  localparam logic CMD_FALL = 1'b1;

  typedef struct packed {
    logic [WIDTH_W-1:0] deadband_low;
    logic [WIDTH_W-1:0] deadband_high;
    logic [CNT_W-1:0]   window_pulses;
    logic [CNT_W-1:0]   trigger_count;
    logic [WIDTH_W-1:0] full_left_width;
    logic [WIDTH_W-1:0] full_right_width;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WIDTH,
    S_PULSE,
    S_AVG,
    S_PREP,
    S_MAP,
    S_QUO,
    S_OUT
  } state_t;

endpackage

>>> rtl/core/rcpq_cfg.sv
// Configuration register file of the RC PWM pulse qualifier.
module rcpq_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic [rcpq_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [rcpq_pkg::CFG_DATA_W-1:0]   cfg_data,
  output rcpq_pkg::cfg_t                    cfg
);

  rcpq_pkg::cfg_t cfg_r;
  rcpq_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_addr)
        rcpq_pkg::REG_DEADBAND_LOW:     cfg_nxt.deadband_low     = cfg_data;
        rcpq_pkg::REG_DEADBAND_HIGH:    cfg_nxt.deadband_high    = cfg_data;
        rcpq_pkg::REG_WINDOW_PULSES:
          cfg_nxt.window_pulses = cfg_data[rcpq_pkg::CNT_W-1:0];
        rcpq_pkg::REG_TRIGGER_COUNT:
          cfg_nxt.trigger_count = cfg_data[rcpq_pkg::CNT_W-1:0];
        rcpq_pkg::REG_FULL_LEFT_WIDTH:  cfg_nxt.full_left_width  = cfg_data;
        rcpq_pkg::REG_FULL_RIGHT_WIDTH: cfg_nxt.full_right_width = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadband_low     <= rcpq_pkg::DEADBAND_LOW_RST;
      cfg_r.deadband_high    <= rcpq_pkg::DEADBAND_HIGH_RST;
      cfg_r.window_pulses    <= rcpq_pkg::WINDOW_PULSES_RST;
      cfg_r.trigger_count    <= rcpq_pkg::TRIGGER_COUNT_RST;
      cfg_r.full_left_width  <= rcpq_pkg::FULL_LEFT_WIDTH_RST;
      cfg_r.full_right_width <= rcpq_pkg::FULL_RIGHT_WIDTH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/core/rcpq_div.sv
// Shared restoring divider, one quotient bit per cycle.
module rcpq_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [rcpq_pkg::DIV_DW-1:0]     dividend,
  input  logic [rcpq_pkg::DIV_VW-1:0]     divisor,
  output logic                            done,
  output logic [rcpq_pkg::DIV_DW-1:0]     quotient
);

  localparam int DW    = rcpq_pkg::DIV_DW;
  localparam int VW    = rcpq_pkg::DIV_VW;
  localparam int STEPW = $clog2(DW);
  localparam logic [STEPW-1:0] LAST_STEP = STEPW'(DW - 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [STEPW-1:0] step_r, step_nxt;
  logic [DW-1:0]    quo_r, quo_nxt;
  logic [VW-1:0]    rem_r, rem_nxt;
  logic [VW-1:0]    dvs_r, dvs_nxt;

  logic [VW:0] rem_sh;
  logic [VW:0] trial;
  logic        ge;

  always_comb begin
    // Bring down the next dividend bit and try the subtraction.
    rem_sh = {rem_r, quo_r[DW-1]};
    trial  = rem_sh - {1'b0, dvs_r};
    ge     = (rem_sh >= {1'b0, dvs_r});

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt  = {quo_r[DW-2:0], ge};
      rem_nxt  = ge ? trial[VW-1:0] : rem_sh[VW-1:0];
      step_nxt = step_r + 1'b1;
      if (step_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> rtl/core/rc_pwm_pulse_qualifier.sv
// Top level of the RC PWM pulse qualifier: edge capture, manual detection, averaging.
// A rising-edge item stores its time; the block is ready again in the next cycle.
// A falling-edge item passes the width, pulse, prep and output states, plus the
// averaging state when it completes a block and the map and quotient states when
// manual; the percent division runs one bit a cycle on the one shared 24-bit divider.
// A result waits in the output register; the block is ready again once it is loaded.
// Synchronous active-low reset restores register defaults and clears all counters.
module rc_pwm_pulse_qualifier #(
  parameter int AVG_SAMPLES = rcpq_pkg::AVG_SAMPLES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [rcpq_pkg::TIME_W-1:0]         in_tdata,  // [31:0] edge_time_us
  input  logic                                in_tuser,  // [0] cmd
  // Result stream.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] is_manual, [16:1] average_width, [17] average_updated,
  // [33:18] steering_percent, [39:34] zero
  output logic [rcpq_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // Configuration write channel.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rcpq_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [rcpq_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int TW     = rcpq_pkg::TIME_W;
  localparam int WW     = rcpq_pkg::WIDTH_W;
  localparam int CW     = rcpq_pkg::CNT_W;
  localparam int DW     = rcpq_pkg::DIV_DW;
  localparam int VW     = rcpq_pkg::DIV_VW;
  localparam int SCNT_W = $clog2(AVG_SAMPLES + 1);
  localparam int SUM_W  = WW + $clog2(AVG_SAMPLES);
  localparam int PW     = DW + 1;   // signed product width
  localparam int VALW   = DW + 2;   // signed percent before saturation
  localparam int MW     = SUM_W + 2;
  localparam int APW    = SUM_W + MW;
  localparam int AVG_SH = SUM_W + $clog2(AVG_SAMPLES);

  localparam logic [SCNT_W:0]  AVG_CMP  = (SCNT_W + 1)'(AVG_SAMPLES);
  // Rounded-up reciprocal of the block length; exact for every sum of SUM_W bits.
  localparam logic [MW-1:0]    AVG_RECIP =
    MW'(((64'd1 << AVG_SH) + 64'(AVG_SAMPLES) - 64'd1) / 64'(AVG_SAMPLES));
  localparam logic [PW-1:0]    SCALE    = PW'(200);
  localparam logic [VALW-1:0]  PCT_BASE = VALW'(100);
  localparam logic signed [VALW-1:0] PCT_MAX = VALW'(32767);
  localparam logic signed [VALW-1:0] PCT_MIN = -(VALW'(32768));

  rcpq_pkg::cfg_t cfg;

  rcpq_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign cfg_ready = 1'b1;

  logic          div_start;
  logic [DW-1:0] div_dvd;
  logic [VW-1:0] div_dvs;
  logic          div_done;
  logic [DW-1:0] div_quo;

  rcpq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  rcpq_pkg::state_t state_r, state_nxt;

  logic [TW-1:0]     rise_r, rise_nxt;
  logic [TW-1:0]     time_r, time_nxt;
  logic [WW-1:0]     width_r, width_nxt;
  logic [CW-1:0]     wc_r, wc_nxt;
  logic [CW-1:0]     oc_r, oc_nxt;
  logic              manual_r, manual_nxt;
  logic [SCNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [WW-1:0]     avg_r, avg_nxt;
  logic              upd_r, upd_nxt;
  logic [WW:0]       diff_r, diff_nxt;
  logic [WW:0]       span_r, span_nxt;
  logic              neg_r, neg_nxt;
  logic [WW-1:0]     pct_r, pct_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [rcpq_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic [TW-1:0]     elapsed;
  logic [WW-1:0]     width_sat;
  logic [CW:0]       wc_inc;
  logic [CW-1:0]     oc_base;
  logic [CW:0]       oc_inc;
  logic              outlier;
  logic [SUM_W-1:0]  sum_new;
  logic [SCNT_W:0]   cnt_inc;
  logic [APW-1:0]    avg_prod;
  logic [PW-1:0]     prod;
  logic [PW-1:0]     prod_abs;
  logic [WW:0]       span_abs;
  logic [VALW-1:0]   quo_x;
  logic signed [VALW-1:0] pct_val;

  always_comb begin
    elapsed   = time_r - rise_r;
    width_sat = (|elapsed[TW-1:WW]) ? {WW{1'b1}} : elapsed[WW-1:0];

    // Counters compare after the increment at one extra bit of precision.
    wc_inc  = {1'b0, wc_r} + 1'b1;
    oc_base = (wc_inc > {1'b0, cfg.window_pulses}) ? '0 : oc_r;
    oc_inc  = {1'b0, oc_base} + 1'b1;
    outlier = (width_r < cfg.deadband_low) || (width_r > cfg.deadband_high);
    sum_new = sum_r + SUM_W'(width_r);
    cnt_inc = {1'b0, cnt_r} + 1'b1;

    avg_prod = APW'(sum_r) * APW'(AVG_RECIP);

    prod     = {{(PW - WW - 1){diff_r[WW]}}, diff_r} * SCALE;
    prod_abs = prod[PW-1] ? (~prod + 1'b1) : prod;
    span_abs = span_r[WW] ? (~span_r + 1'b1) : span_r;

    quo_x   = {2'b00, div_quo};
    pct_val = neg_r ? $signed(PCT_BASE + quo_x) : $signed(PCT_BASE - quo_x);

    state_nxt     = state_r;
    rise_nxt      = rise_r;
    time_nxt      = time_r;
    width_nxt     = width_r;
    wc_nxt        = wc_r;
    oc_nxt        = oc_r;
    manual_nxt    = manual_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    avg_nxt       = avg_r;
    upd_nxt       = upd_r;
    diff_nxt      = diff_r;
    span_nxt      = span_r;
    neg_nxt       = neg_r;
    pct_nxt       = pct_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    div_start     = 1'b0;
    div_dvd       = prod_abs[DW-1:0];
    div_dvs       = span_abs[VW-1:0];

    case (state_r)
      rcpq_pkg::S_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == rcpq_pkg::CMD_FALL) begin
            time_nxt  = in_tdata;
            state_nxt = rcpq_pkg::S_WIDTH;
          end else begin
            rise_nxt = in_tdata;
          end
        end
      end
      rcpq_pkg::S_WIDTH: begin
        width_nxt = width_sat;
        state_nxt = rcpq_pkg::S_PULSE;
      end
      rcpq_pkg::S_PULSE: begin
        wc_nxt = (wc_inc > {1'b0, cfg.window_pulses}) ? '0 : wc_inc[CW-1:0];
        if (outlier) begin
          if (oc_inc > {1'b0, cfg.trigger_count}) begin
            manual_nxt = 1'b1;
            oc_nxt     = '0;
          end else begin
            oc_nxt = oc_inc[CW-1:0];
          end
        end else begin
          manual_nxt = 1'b0;
          oc_nxt     = oc_base;
        end
        sum_nxt = sum_new;
        if (cnt_inc >= AVG_CMP) begin
          // Block complete: the full sum is averaged in the next cycle.
          cnt_nxt   = '0;
          upd_nxt   = 1'b1;
          state_nxt = rcpq_pkg::S_AVG;
        end else begin
          cnt_nxt   = cnt_inc[SCNT_W-1:0];
          upd_nxt   = 1'b0;
          state_nxt = rcpq_pkg::S_PREP;
        end
      end
      rcpq_pkg::S_AVG: begin
        avg_nxt   = avg_prod[AVG_SH +: WW];
        sum_nxt   = '0;
        state_nxt = rcpq_pkg::S_PREP;
      end
      rcpq_pkg::S_PREP: begin
        if (manual_r && (cfg.full_left_width != cfg.full_right_width)) begin
          diff_nxt  = {1'b0, avg_r} - {1'b0, cfg.full_left_width};
          span_nxt  = {1'b0, cfg.full_right_width} - {1'b0, cfg.full_left_width};
          state_nxt = rcpq_pkg::S_MAP;
        end else begin
          pct_nxt   = '0;
          state_nxt = rcpq_pkg::S_OUT;
        end
      end
      rcpq_pkg::S_MAP: begin
        // Divide magnitudes so the quotient truncates toward zero.
        div_start = 1'b1;
        neg_nxt   = prod[PW-1] ^ span_r[WW];
        state_nxt = rcpq_pkg::S_QUO;
      end
      rcpq_pkg::S_QUO: begin
        if (div_done) begin
          if (pct_val > PCT_MAX) begin
            pct_nxt = PCT_MAX[WW-1:0];
          end else if (pct_val < PCT_MIN) begin
            pct_nxt = PCT_MIN[WW-1:0];
          end else begin
            pct_nxt = pct_val[WW-1:0];
          end
          state_nxt = rcpq_pkg::S_OUT;
        end
      end
      rcpq_pkg::S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'b000000, pct_r, upd_r, avg_r, manual_r};
          state_nxt     = rcpq_pkg::S_IDLE;
        end
      end
      default: state_nxt = rcpq_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rcpq_pkg::S_IDLE;
      rise_r      <= '0;
      wc_r        <= '0;
      oc_r        <= '0;
      manual_r    <= 1'b0;
      cnt_r       <= '0;
      sum_r       <= '0;
      avg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rise_r      <= rise_nxt;
      wc_r        <= wc_nxt;
      oc_r        <= oc_nxt;
      manual_r    <= manual_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      avg_r       <= avg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    time_r     <= time_nxt;
    width_r    <= width_nxt;
    upd_r      <= upd_nxt;
    diff_r     <= diff_nxt;
    span_r     <= span_nxt;
    neg_r      <= neg_nxt;
    pct_r      <= pct_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == rcpq_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> rtl/core/rcpq_checker.sv
// Port-level checks of the RC PWM pulse qualifier and their binding.
module rcpq_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [rcpq_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // A falling edge starts a multi-cycle measurement, so the input closes.
  a_fall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == rcpq_pkg::CMD_FALL)) |=> !in_tready)
    else $error("input still ready after a falling-edge item");

  // A rising edge only stores its time; the input is open again next cycle.
  a_rise_quick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == rcpq_pkg::CMD_RISE)) |=> in_tready)
    else $error("input not ready after a rising-edge item");

  // Steering percent is zero whenever the manual flag is clear.
  a_pct_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> (out_tdata[33:18] == 16'd0))
    else $error("non-zero steering percent without manual flag");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result item changed or dropped");

endmodule

bind rc_pwm_pulse_qualifier rcpq_checker u_rcpq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> tb/tb.sv
// Self-checking testbench for the RC PWM pulse qualifier, with its scoreboard.
module tb;

  localparam int QUIET_LIMIT = 5000;
  localparam int IDLE_PCT    = 21;

  typedef struct {
    logic                         manual;
    logic [rcpq_pkg::WIDTH_W-1:0] avg_us;
    logic                         updated;
    logic [rcpq_pkg::WIDTH_W-1:0] pct;
  } pulse_reading_t;

  // Tracks the block's state and configuration and holds the readings still due.
  class pulse_ledger;
    logic [rcpq_pkg::WIDTH_W-1:0] dband_lo, dband_hi, left_us, right_us;
    logic [rcpq_pkg::CNT_W-1:0]   window_len, trigger_len;
    logic [rcpq_pkg::TIME_W-1:0]  rise_us;
    logic [rcpq_pkg::CNT_W-1:0]   window_cnt, outlier_cnt;
    logic                         manual;
    logic [3:0]                   sample_cnt;
    logic [18:0]                  sample_sum;
    logic [rcpq_pkg::WIDTH_W-1:0] avg_us;
    pulse_reading_t               due_readings[$];
    int                           errors;

    function new();
      dband_lo    = rcpq_pkg::DEADBAND_LOW_RST;
      dband_hi    = rcpq_pkg::DEADBAND_HIGH_RST;
      window_len  = rcpq_pkg::WINDOW_PULSES_RST;
      trigger_len = rcpq_pkg::TRIGGER_COUNT_RST;
      left_us     = rcpq_pkg::FULL_LEFT_WIDTH_RST;
      right_us    = rcpq_pkg::FULL_RIGHT_WIDTH_RST;
      rise_us     = '0;
      window_cnt  = '0;
      outlier_cnt = '0;
      manual      = 1'b0;
      sample_cnt  = '0;
      sample_sum  = '0;
      avg_us      = '0;
      errors      = 0;
    endfunction

    function int pending();
      return due_readings.size();
    endfunction

    task report(string what);
      errors++;
      $display("tb: mismatch: %s", what);
    endtask

    function void write_reg(logic [rcpq_pkg::CFG_ADDR_W-1:0] idx,
                            logic [rcpq_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        rcpq_pkg::REG_DEADBAND_LOW:     dband_lo = val;
        rcpq_pkg::REG_DEADBAND_HIGH:    dband_hi = val;
        rcpq_pkg::REG_WINDOW_PULSES:    window_len = val[rcpq_pkg::CNT_W-1:0];
        rcpq_pkg::REG_TRIGGER_COUNT:    trigger_len = val[rcpq_pkg::CNT_W-1:0];
        rcpq_pkg::REG_FULL_LEFT_WIDTH:  left_us = val;
        rcpq_pkg::REG_FULL_RIGHT_WIDTH: right_us = val;
        default: ;
      endcase
    endfunction

    // Linear map: 100 at full left, -100 at full right, truncated toward zero.
    function logic [rcpq_pkg::WIDTH_W-1:0] steer_percent(logic [rcpq_pkg::WIDTH_W-1:0] a);
      longint span, m;
      span = longint'(right_us) - longint'(left_us);
      if (span == 0) return '0;
      m = (longint'(a) - longint'(left_us)) * 200 / span - 100;
      m = -m;
      if (m > 32767) m = 32767;
      if (m < -32768) m = -32768;
      return m[rcpq_pkg::WIDTH_W-1:0];
    endfunction

    function void note_edge(logic cmd, logic [rcpq_pkg::TIME_W-1:0] t);
      logic [rcpq_pkg::TIME_W-1:0]  diff;
      logic [rcpq_pkg::WIDTH_W-1:0] w;
      logic [rcpq_pkg::CNT_W:0]     wc, oc;
      pulse_reading_t               r;
      if (cmd == rcpq_pkg::CMD_RISE) begin
        rise_us = t;
        return;
      end
      // Counters are compared one bit wider, so a limit of 63 still wraps them.
      wc = {1'b0, window_cnt} + 1'b1;
      if (wc > {1'b0, window_len}) begin
        wc = '0;
        outlier_cnt = '0;
      end
      window_cnt = wc[rcpq_pkg::CNT_W-1:0];
      diff = t - rise_us;
      w = (diff > 32'h0000_FFFF) ? 16'hFFFF : diff[rcpq_pkg::WIDTH_W-1:0];
      if (w < dband_lo || w > dband_hi) begin
        oc = {1'b0, outlier_cnt} + 1'b1;
        if (oc > {1'b0, trigger_len}) begin
          manual = 1'b1;
          oc = '0;
        end
        outlier_cnt = oc[rcpq_pkg::CNT_W-1:0];
      end else begin
        manual = 1'b0;
      end
      sample_sum = sample_sum + 19'(w);
      sample_cnt = sample_cnt + 4'd1;
      r.updated = 1'b0;
      if (sample_cnt >= rcpq_pkg::AVG_SAMPLES_DEF) begin
        avg_us = 16'(sample_sum / rcpq_pkg::AVG_SAMPLES_DEF);
        sample_cnt = '0;
        sample_sum = '0;
        r.updated = 1'b1;
      end
      r.manual = manual;
      r.avg_us = avg_us;
      r.pct    = manual ? steer_percent(avg_us) : '0;
      due_readings.push_back(r);
    endfunction

    task check_result(logic [rcpq_pkg::OUT_TDATA_W-1:0] d);
      pulse_reading_t e;
      if (due_readings.size() == 0) begin
        report($sformatf("result %h with nothing due", d));
        return;
      end
      e = due_readings.pop_front();
      if (d[0] !== e.manual)
        report($sformatf("is_manual %b, expected %b", d[0], e.manual));
      if (d[16:1] !== e.avg_us)
        report($sformatf("average_width %0d, expected %0d", d[16:1], e.avg_us));
      if (d[17] !== e.updated)
        report($sformatf("average_updated %b, expected %b", d[17], e.updated));
      if (d[33:18] !== e.pct)
        report($sformatf("steering_percent %0d, expected %0d",
                         $signed(d[33:18]), $signed(e.pct)));
      if (d[rcpq_pkg::OUT_TDATA_W-1:34] !== '0)
        report($sformatf("padding bits %b not zero", d[rcpq_pkg::OUT_TDATA_W-1:34]));
    endtask
  endclass

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [rcpq_pkg::TIME_W-1:0]      in_tdata = '0;
  logic                             in_tuser = rcpq_pkg::CMD_RISE;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [rcpq_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [rcpq_pkg::CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [rcpq_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  logic                             calm = 1'b0;
  logic [rcpq_pkg::TIME_W-1:0]      clock_us = 32'h0003_0000;
  int                               quiet_cycles = 0;
  pulse_ledger                      sb;

  rc_pwm_pulse_qualifier dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Every handshake is observed here, from the values just before the edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_addr, cfg_data);
      if (in_tvalid && in_tready) sb.note_edge(in_tuser, in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if ((cfg_valid && cfg_ready) || (in_tvalid && in_tready) ||
          (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end else begin
        quiet_cycles++;
      end
    end
  end

  function automatic bit take_break();
    return !calm && ($urandom_range(99) < IDLE_PCT);
  endfunction

  task automatic send_edge(input logic cmd, input logic [rcpq_pkg::TIME_W-1:0] t);
    while (take_break()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= t;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // A rising-edge item leaves no result behind, so allow the block to finish it.
  task automatic settle();
    drain();
    repeat (16) @(posedge clk);
  endtask

  task automatic write_regs(input logic [15:0] lo, input logic [15:0] hi,
                            input logic [5:0] win, input logic [5:0] trig,
                            input logic [15:0] left, input logic [15:0] right);
    logic [rcpq_pkg::CFG_ADDR_W-1:0] idx [6];
    logic [rcpq_pkg::CFG_DATA_W-1:0] val [6];
    idx = '{rcpq_pkg::REG_DEADBAND_LOW, rcpq_pkg::REG_DEADBAND_HIGH,
            rcpq_pkg::REG_WINDOW_PULSES, rcpq_pkg::REG_TRIGGER_COUNT,
            rcpq_pkg::REG_FULL_LEFT_WIDTH, rcpq_pkg::REG_FULL_RIGHT_WIDTH};
    val = '{lo, hi, {10'd0, win}, {10'd0, trig}, left, right};
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_addr  <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // Pulse width drawn according to the style of the current burst.
  function automatic logic [rcpq_pkg::TIME_W-1:0] pick_width(int style);
    logic [rcpq_pkg::TIME_W-1:0] lo, hi;
    lo = {16'd0, sb.dband_lo};
    hi = {16'd0, sb.dband_hi};
    if (style < 30) begin
      if (lo <= hi) return lo + $urandom_range(hi - lo);
      return $urandom_range(2000, 1000);
    end
    if (style < 65) return $urandom_range(2200, 800);
    if (style < 80) begin
      case ($urandom_range(3))
        0: return lo - 1;
        1: return lo;
        2: return hi;
        default: return hi + 1;
      endcase
    end
    case ($urandom_range(3))
      0: return $urandom();
      1: return '0;
      2: return 32'h0000_FFFF;
      default: return $urandom_range(65535);
    endcase
  endfunction

  // Mostly rise/fall pairs in bursts of similar widths, plus stray edges.
  task automatic run_traffic(input int n_items);
    int sent, burst_left, style, pick;
    logic [rcpq_pkg::TIME_W-1:0] w;
    sent = 0;
    burst_left = 0;
    style = 0;
    while (sent < n_items) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(30, 3);
        style = $urandom_range(99);
      end
      burst_left--;
      if ($urandom_range(15) == 0) clock_us = $urandom();
      else clock_us = clock_us + $urandom_range(20000, 100);
      pick = $urandom_range(99);
      if (pick < 5) begin
        send_edge(rcpq_pkg::CMD_RISE, clock_us);
        sent++;
      end else if (pick < 10) begin
        send_edge(rcpq_pkg::CMD_FALL, clock_us);
        sent++;
      end else begin
        w = pick_width(style);
        send_edge(rcpq_pkg::CMD_RISE, clock_us);
        send_edge(rcpq_pkg::CMD_FALL, clock_us + w);
        clock_us = clock_us + w;
        sent += 2;
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Falling edge before any rising edge: measured from a rise time of zero.
    send_edge(rcpq_pkg::CMD_FALL, 32'd1500);
    // A rising edge overwritten by another rising edge, then a width on the lower deadband edge.
    send_edge(rcpq_pkg::CMD_RISE, 32'd1000);
    send_edge(rcpq_pkg::CMD_RISE, 32'd2000);
    send_edge(rcpq_pkg::CMD_FALL, 32'd3420);
    // Timestamp wrapping through zero.
    send_edge(rcpq_pkg::CMD_RISE, 32'hFFFF_FF00);
    send_edge(rcpq_pkg::CMD_FALL, 32'h0000_0500);
    // Saturated widths, and the largest exact one.
    send_edge(rcpq_pkg::CMD_RISE, 32'h0000_0000);
    send_edge(rcpq_pkg::CMD_FALL, 32'hFFFF_FFFF);
    send_edge(rcpq_pkg::CMD_RISE, 32'd100);
    send_edge(rcpq_pkg::CMD_FALL, 32'd65635);
    send_edge(rcpq_pkg::CMD_FALL, 32'd65636);
    // Zero width, then outliers either side which set manual steering.
    send_edge(rcpq_pkg::CMD_RISE, 32'd70000);
    send_edge(rcpq_pkg::CMD_FALL, 32'd70000);
    send_edge(rcpq_pkg::CMD_RISE, 32'd80000);
    send_edge(rcpq_pkg::CMD_FALL, 32'd81419);
    send_edge(rcpq_pkg::CMD_RISE, 32'd90000);
    send_edge(rcpq_pkg::CMD_FALL, 32'd91501);
    // An in-band pulse clears manual steering.
    send_edge(rcpq_pkg::CMD_RISE, 32'd100000);
    send_edge(rcpq_pkg::CMD_FALL, 32'd101500);
    send_edge(rcpq_pkg::CMD_RISE, 32'd110000);
    send_edge(rcpq_pkg::CMD_FALL, 32'd111000);
    send_edge(rcpq_pkg::CMD_RISE, 32'd120000);
    send_edge(rcpq_pkg::CMD_FALL, 32'd122000);

    calm <= 1'b1;
    run_traffic(175);
    calm <= 1'b0;

    settle();
    write_regs(16'd0, 16'hFFFF, 6'd63, 6'd63, 16'd0, 16'hFFFF);
    run_traffic(175);

    settle();
    write_regs(16'hFFFF, 16'd0, 6'd1, 6'd1, 16'hFFFF, 16'd0);
    run_traffic(175);

    // Zero span between the full-left and full-right widths.
    settle();
    write_regs(16'd1450, 16'd1470, 6'd63, 6'd1, 16'd1500, 16'd1500);
    run_traffic(175);

    // Tiny span drives the percent into negative saturation.
    settle();
    write_regs(16'd1400, 16'd1600, 6'd10, 6'd3, 16'd0, 16'd1);
    run_traffic(90);
    drain();
    run_traffic(85);

    // A tiny span near the top of the range drives it into positive saturation.
    settle();
    write_regs(16'd1300, 16'd1700, 6'd30, 6'd2, 16'd65534, 16'hFFFF);
    run_traffic(175);

    settle();
    write_regs(16'($urandom_range(1480, 1350)), 16'($urandom_range(1650, 1490)),
               6'($urandom_range(63, 1)), 6'($urandom_range(63, 1)),
               16'($urandom_range(1200, 800)), 16'($urandom_range(2200, 1800)));
    run_traffic(175);

    settle();
    write_regs(16'($urandom_range(65535)), 16'($urandom_range(65535)),
               6'($urandom_range(63, 1)), 6'($urandom_range(63, 1)),
               16'($urandom_range(65535)), 16'($urandom_range(65535)));
    run_traffic(175);

    drain();
    repeat (100) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

>>> rc_pwm_pulse_qualifier.f
rtl/core/rcpq_pkg.sv
rtl/core/rcpq_cfg.sv
rtl/core/rcpq_div.sv
rtl/core/rc_pwm_pulse_qualifier.sv
rtl/core/rcpq_checker.sv
tb/tb.sv
